// ----- design/tsf_pkg.sv -----
// ----------------------------------------------------------------------------
// tsf_pkg: shared types and constants for the telemetry sentence framer
// Character codes, configuration register indexes, reset values and the
// step record that passes from the filter to the trailer stage.
// ----------------------------------------------------------------------------
package tsf_pkg;

    localparam int CHAR_W = 8;
    localparam int CRC_W  = 16;
    localparam int SKIP_W = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;
    localparam logic [CHAR_W-1:0] CHAR_STAR  = 8'h2A;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_KEPT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CRC_SKIP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CRC_SEED = 2'd2;

    localparam logic [CHAR_W-1:0] MAX_KEPT_RST = 8'd60;
    localparam logic [SKIP_W-1:0] CRC_SKIP_RST = 2'd2;
    localparam logic [CRC_W-1:0]  CRC_SEED_RST = 16'hFFFF;
    localparam logic [CRC_W-1:0]  CRC_POLY     = 16'h1021;

    // outcome of one accepted character
    typedef struct packed {
        logic              keep;
        logic              line_end;
        logic [CRC_W-1:0]  crc;
    } t_step;

endpackage

// ----- design/tsf_stream_if.sv -----
// ----------------------------------------------------------------------------
// tsf_in_if / tsf_out_if: valid/ready word channels of the framer
// The input channel carries raw characters, the output channel framed
// characters with an end-of-sentence flag.
// ----------------------------------------------------------------------------
interface tsf_in_if;
    logic                         valid;
    logic                         ready;
    logic [tsf_pkg::CHAR_W-1:0]   in_char;

    modport source (output valid, output in_char, input ready);
    modport sink   (input valid, input in_char, output ready);
endinterface

interface tsf_out_if;
    logic                         valid;
    logic                         ready;
    logic [tsf_pkg::CHAR_W-1:0]   out_char;
    logic                         sentence_end;

    modport source (output valid, output out_char, output sentence_end, input ready);
    modport sink   (input valid, input out_char, input sentence_end, output ready);
endinterface

// ----- design/tsf_filter.sv -----
// ----------------------------------------------------------------------------
// tsf_filter: character classification and running CRC
// Decides keep / drop / line end for each accepted word and holds the
// kept count and the CRC-16 register of the current sentence.
// ----------------------------------------------------------------------------
module tsf_filter (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic [tsf_pkg::CHAR_W-1:0]     i_char,
    input  logic [tsf_pkg::CHAR_W-1:0]     i_max_kept,
    input  logic [tsf_pkg::SKIP_W-1:0]     i_crc_skip,
    input  logic [tsf_pkg::CRC_W-1:0]      i_crc_seed,
    output tsf_pkg::t_step                 o_step
);

    logic [tsf_pkg::CRC_W-1:0]  r_crc, n_crc;
    logic [tsf_pkg::CHAR_W-1:0] r_kept, n_kept;
    logic                       line_end;
    logic                       keep;
    logic                       in_crc;

    // one byte through the CRC, MSB first
    function automatic logic [tsf_pkg::CRC_W-1:0] crc_byte(
        input logic [tsf_pkg::CRC_W-1:0]  crc,
        input logic [tsf_pkg::CHAR_W-1:0] b
    );
        logic [tsf_pkg::CRC_W-1:0] r;
        r = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (r[tsf_pkg::CRC_W-1]) begin
                r = {r[tsf_pkg::CRC_W-2:0], 1'b0} ^ tsf_pkg::CRC_POLY;
            end else begin
                r = {r[tsf_pkg::CRC_W-2:0], 1'b0};
            end
        end
        return r;
    endfunction

    assign line_end = (i_char == tsf_pkg::CHAR_CR) || (i_char == tsf_pkg::CHAR_LF);
    assign keep     = !line_end && (i_char != tsf_pkg::CHAR_SPACE) && (r_kept < i_max_kept);
    assign in_crc   = r_kept >= {6'd0, i_crc_skip};

    assign o_step.keep     = keep;
    assign o_step.line_end = line_end;
    assign o_step.crc      = r_crc;

    always_comb begin
        n_crc  = r_crc;
        n_kept = r_kept;
        if (i_accept) begin
            if (line_end) begin
                n_crc  = i_crc_seed;
                n_kept = '0;
            end else if (keep) begin
                if (in_crc) begin
                    n_crc = crc_byte(r_crc, i_char);
                end
                n_kept = r_kept + 8'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc  <= tsf_pkg::CRC_SEED_RST;
            r_kept <= '0;
        end else begin
            r_crc  <= n_crc;
            r_kept <= n_kept;
        end
    end

endmodule

// ----- design/tsf_tail.sv -----
// ----------------------------------------------------------------------------
// tsf_tail: output register and trailer sequencer
// Registers each kept character for the output channel, and after a line
// end walks out '*', four hex digits of the CRC and the closing newline.
// ----------------------------------------------------------------------------
module tsf_tail (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic [tsf_pkg::CHAR_W-1:0]     i_char,
    input  tsf_pkg::t_step                 i_step,
    output logic                           o_can_take,
    tsf_out_if.source                      o_out
);

    // words of the trailer still to send after '*'
    localparam logic [2:0] LEFT_NONE = 3'd0;
    localparam logic [2:0] LEFT_NL   = 3'd1;
    localparam logic [2:0] LEFT_HEX0 = 3'd2;
    localparam logic [2:0] LEFT_HEX1 = 3'd3;
    localparam logic [2:0] LEFT_HEX2 = 3'd4;
    localparam logic [2:0] LEFT_HEX3 = 3'd5;

    logic                          r_valid, n_valid;
    logic [tsf_pkg::CHAR_W-1:0]    r_char, n_char;
    logic                          r_end, n_end;
    logic [2:0]                    r_left, n_left;
    logic [tsf_pkg::CRC_W-1:0]     r_crc, n_crc;
    logic                          load_en;
    logic [tsf_pkg::CHAR_W-1:0]    tail_char;

    function automatic logic [tsf_pkg::CHAR_W-1:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10) begin
            return 8'h30 + {4'd0, nib};
        end
        return 8'h37 + {4'd0, nib};
    endfunction

    assign load_en    = !r_valid || o_out.ready;
    assign o_can_take = load_en && (r_left == LEFT_NONE);

    always_comb begin
        case (r_left)
            LEFT_HEX3: tail_char = hex_char(r_crc[15:12]);
            LEFT_HEX2: tail_char = hex_char(r_crc[11:8]);
            LEFT_HEX1: tail_char = hex_char(r_crc[7:4]);
            LEFT_HEX0: tail_char = hex_char(r_crc[3:0]);
            LEFT_NL:   tail_char = tsf_pkg::CHAR_LF;
            default:   tail_char = tsf_pkg::CHAR_LF;
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        n_char  = r_char;
        n_end   = r_end;
        n_left  = r_left;
        n_crc   = r_crc;
        if (load_en) begin
            if (r_left != LEFT_NONE) begin
                // advance through the trailer
                n_valid = 1'b1;
                n_char  = tail_char;
                n_end   = (r_left == LEFT_NL);
                n_left  = r_left - 3'd1;
            end else if (i_accept && i_step.line_end) begin
                n_valid = 1'b1;
                n_char  = tsf_pkg::CHAR_STAR;
                n_end   = 1'b0;
                n_left  = LEFT_HEX3;
                n_crc   = i_step.crc;
            end else if (i_accept && i_step.keep) begin
                n_valid = 1'b1;
                n_char  = i_char;
                n_end   = 1'b0;
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_left  <= LEFT_NONE;
        end else begin
            r_valid <= n_valid;
            r_left  <= n_left;
        end
        r_char <= n_char;
        r_end  <= n_end;
        r_crc  <= n_crc;
    end

    assign o_out.valid        = r_valid;
    assign o_out.out_char     = r_char;
    assign o_out.sentence_end = r_end;

endmodule

// ----- design/telemetry_sentence_framer_crc16.sv -----
// ----------------------------------------------------------------------------
// telemetry_sentence_framer_crc16: telemetry sentence framer with CRC trailer
// Drops spaces, passes up to max_kept characters per sentence and closes
// each sentence with '*', a CRC-16/CCITT-FALSE in hex and a newline.
// ----------------------------------------------------------------------------
//   channel  | dir | word                       | accepted when
//   ---------+-----+----------------------------+-----------------------
//   i_in     | in  | in_char                    | valid && ready
//   o_out    | out | out_char, sentence_end     | valid && ready
//   i_cfg_*  | in  | idx, data                  | i_cfg_we
//
// With the output free, one word is taken per cycle and a kept character
// appears in the output register on the next cycle. A line end gives six
// output words, one per free cycle; input stalls until the last is loaded.
// Output stalls back up into the input through the single output register.
// Synchronous reset restores the default configuration and an empty sentence.
module telemetry_sentence_framer_crc16 (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [tsf_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [tsf_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    tsf_in_if.sink                             i_in,
    tsf_out_if.source                          o_out
);

    logic [tsf_pkg::CHAR_W-1:0] r_max_kept;
    logic [tsf_pkg::SKIP_W-1:0] r_crc_skip;
    logic [tsf_pkg::CRC_W-1:0]  r_crc_seed;
    logic                       can_take;
    logic                       accept;
    tsf_pkg::t_step             step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_kept <= tsf_pkg::MAX_KEPT_RST;
            r_crc_skip <= tsf_pkg::CRC_SKIP_RST;
            r_crc_seed <= tsf_pkg::CRC_SEED_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tsf_pkg::CFG_MAX_KEPT: r_max_kept <= i_cfg_data[tsf_pkg::CHAR_W-1:0];
                tsf_pkg::CFG_CRC_SKIP: r_crc_skip <= i_cfg_data[tsf_pkg::SKIP_W-1:0];
                tsf_pkg::CFG_CRC_SEED: r_crc_seed <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign i_in.ready = can_take;
    assign accept     = i_in.valid && can_take;

    tsf_filter u_filter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_char     (i_in.in_char),
        .i_max_kept (r_max_kept),
        .i_crc_skip (r_crc_skip),
        .i_crc_seed (r_crc_seed),
        .o_step     (step)
    );

    tsf_tail u_tail (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_char     (i_in.in_char),
        .i_step     (step),
        .o_can_take (can_take),
        .o_out      (o_out)
    );

endmodule

// ----- sim/tsf_framer_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tsf_framer_checker: scoreboard for the telemetry sentence framer
// Watches the character input, the framed output and the register write
// port. Predicts every framed word with its own CRC-16 and count state and
// compares each output word against the oldest prediction.
// ----------------------------------------------------------------------------
module tsf_framer_checker import tsf_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    tsf_in_if                      in_ch,
    tsf_out_if                     out_ch,
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_words_checked,
    output int                     o_sentences
);

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_framed;

    t_framed framed_q[$];

    logic [CHAR_W-1:0] lim_kept;
    logic [SKIP_W-1:0] skip_n;
    logic [CRC_W-1:0]  seed_val;
    logic [CRC_W-1:0]  run_crc;
    logic [CHAR_W-1:0] kept_n;

    int fail_n    = 0;
    int pending_n = 0;
    int checked_n = 0;
    int closed_n  = 0;

    assign o_fail_count    = fail_n;
    assign o_pending       = pending_n;
    assign o_words_checked = checked_n;
    assign o_sentences     = closed_n;

    function automatic logic [CRC_W-1:0] crc_update(input logic [CRC_W-1:0] crc,
                                                    input logic [CHAR_W-1:0] b);
        logic [CRC_W-1:0] r;
        r = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            r = r[CRC_W-1] ? ((r << 1) ^ CRC_POLY) : (r << 1);
        end
        return r;
    endfunction

    // upper-case ASCII hex digit
    function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) begin
            return 8'h30 + {4'h0, n};
        end
        return 8'h37 + {4'h0, n};
    endfunction

    task automatic predict_char(input logic [CHAR_W-1:0] c);
        if (c == CHAR_CR || c == CHAR_LF) begin
            framed_q.push_back('{ch: CHAR_STAR, last: 1'b0});
            framed_q.push_back('{ch: hex_char(run_crc[15:12]), last: 1'b0});
            framed_q.push_back('{ch: hex_char(run_crc[11:8]), last: 1'b0});
            framed_q.push_back('{ch: hex_char(run_crc[7:4]), last: 1'b0});
            framed_q.push_back('{ch: hex_char(run_crc[3:0]), last: 1'b0});
            framed_q.push_back('{ch: CHAR_LF, last: 1'b1});
            run_crc = seed_val;
            kept_n  = '0;
        end else if (c != CHAR_SPACE && kept_n < lim_kept) begin
            // leading kept characters stay out of the checksum
            if (kept_n >= {6'd0, skip_n}) begin
                run_crc = crc_update(run_crc, c);
            end
            kept_n = kept_n + 8'd1;
            framed_q.push_back('{ch: c, last: 1'b0});
        end
    endtask

    task automatic check_word(input logic [CHAR_W-1:0] ch, input logic last);
        t_framed exp_w;
        if (framed_q.size() == 0) begin
            $display("%0t: unexpected word, expected none, got char %02h end %0b",
                     $time, ch, last);
            fail_n++;
        end else begin
            exp_w = framed_q.pop_front();
            if (exp_w.ch !== ch || exp_w.last !== last) begin
                $display("%0t: word mismatch, expected char %02h end %0b, got char %02h end %0b",
                         $time, exp_w.ch, exp_w.last, ch, last);
                fail_n++;
            end
        end
        checked_n++;
        if (last === 1'b1) begin
            closed_n++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            lim_kept = MAX_KEPT_RST;
            skip_n   = CRC_SKIP_RST;
            seed_val = CRC_SEED_RST;
            run_crc  = CRC_SEED_RST;
            kept_n   = '0;
            framed_q.delete();
        end else begin
            // compare before predicting: a word leaving now never belongs to
            // a character taken at the same edge
            if (out_ch.valid && out_ch.ready) begin
                check_word(out_ch.out_char, out_ch.sentence_end);
            end
            if (in_ch.valid && in_ch.ready) begin
                predict_char(in_ch.in_char);
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MAX_KEPT: lim_kept = i_cfg_data[CHAR_W-1:0];
                    CFG_CRC_SKIP: skip_n   = i_cfg_data[SKIP_W-1:0];
                    CFG_CRC_SEED: seed_val = i_cfg_data[CRC_W-1:0];
                    default: ;
                endcase
            end
        end
        pending_n = framed_q.size();
    end

endmodule

// ----- sim/telemetry_sentence_framer_crc16_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// telemetry_sentence_framer_crc16_tb: testbench for the sentence framer
// Sends directed and random telemetry sentences under changing register
// settings and handshake pacing; a separate checker predicts and compares
// every framed word.
// ----------------------------------------------------------------------------
module telemetry_sentence_framer_crc16_tb;
    import tsf_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int PHASE_CHARS = 75;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    tsf_in_if  in_ch ();
    tsf_out_if out_ch ();

    int snd_idle_pct = 7;
    int rcv_idle_pct = 65;
    int fail_count;
    int pending;
    int words_checked;
    int sentences;
    int chars_sent = 0;
    int reg_writes = 0;

    telemetry_sentence_framer_crc16 i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    tsf_framer_checker i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .in_ch           (in_ch),
        .out_ch          (out_ch),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_words_checked (words_checked),
        .o_sentences     (sentences)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("telemetry_sentence_framer_crc16_tb failed");
        $finish;
    end

    // receiver back-pressure
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_ch.ready = ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // hold until every predicted word is out and the block has settled
    task automatic wait_drained();
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        wait_drained();
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = data;
        @(negedge i_clk);
        cfg_we = 1'b0;
        reg_writes++;
    endtask

    task automatic send_char(input logic [CHAR_W-1:0] c);
        while ($urandom_range(99) < snd_idle_pct) @(negedge i_clk);
        in_ch.valid   = 1'b1;
        in_ch.in_char = c;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        if (c != CHAR_SPACE) begin
            chars_sent++;
        end
    endtask

    function automatic logic [CHAR_W-1:0] payload_char();
        int r;
        r = $urandom_range(99);
        if (r < 10) begin
            return CHAR_SPACE;
        end
        if (r < 18) begin
            return 8'($urandom_range(255));
        end
        return 8'($urandom_range(126, 33));
    endfunction

    task automatic random_reg_write();
        int r;
        logic [CFG_DATA_W-1:0] v;
        r = $urandom_range(99);
        if (r < 40) begin
            case ($urandom_range(4))
                0: v = 16'd1;
                1: v = 16'd255;
                2: v = 16'd0;
                3: v = 16'($urandom_range(20, 1));
                default: v = 16'($urandom_range(255, 1));
            endcase
            write_reg(CFG_MAX_KEPT, v);
        end else if (r < 65) begin
            write_reg(CFG_CRC_SKIP, 16'($urandom_range(3)));
        end else if (r < 95) begin
            case ($urandom_range(2))
                0: v = 16'h0000;
                1: v = 16'hFFFF;
                default: v = 16'($urandom_range(65535));
            endcase
            write_reg(CFG_CRC_SEED, v);
        end else begin
            write_reg(CFG_UNUSED, 16'($urandom_range(65535)));
        end
    endtask

    task automatic random_sentence();
        int len;
        int r;
        r = $urandom_range(99);
        if (r < 15) begin
            random_reg_write();
        end
        if (r >= 15 && r < 30) begin
            // noise: raw bytes, maybe without a line end
            len = $urandom_range(8, 1);
            repeat (len) send_char(8'($urandom_range(255)));
        end else begin
            len = ($urandom_range(99) < 85) ? $urandom_range(16) : $urandom_range(70, 40);
            send_char("$");
            send_char("$");
            repeat (len) send_char(payload_char());
            case ($urandom_range(2))
                0: send_char(CHAR_CR);
                1: send_char(CHAR_LF);
                default: begin
                    send_char(CHAR_CR);
                    send_char(CHAR_LF);
                end
            endcase
        end
    endtask

    initial begin
        int phase_start;
        in_ch.valid   = 1'b0;
        in_ch.in_char = '0;
        cfg_we        = 1'b0;
        cfg_idx       = '0;
        cfg_data      = '0;
        i_rst_n       = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings: skipped header, spaces, byte extremes, CR LF pair
        send_char("$");
        send_char("$");
        send_char(CHAR_SPACE);
        send_char("A");
        send_char(8'h00);
        send_char(8'hFF);
        send_char(8'h7F);
        send_char(8'h80);
        send_char(CHAR_SPACE);
        send_char(CHAR_CR);
        send_char(CHAR_LF);

        // one kept character, checksum over everything; the zero seed applies from the next sentence
        write_reg(CFG_MAX_KEPT, 16'd1);
        write_reg(CFG_CRC_SKIP, 16'd0);
        write_reg(CFG_CRC_SEED, 16'h0000);
        send_char("Z");
        send_char("Q");
        send_char(CHAR_LF);

        // zero limit keeps nothing
        write_reg(CFG_MAX_KEPT, 16'd0);
        send_char("X");
        send_char(CHAR_CR);

        // seed change inside a sentence applies from the next one
        write_reg(CFG_MAX_KEPT, 16'd255);
        write_reg(CFG_CRC_SKIP, 16'd3);
        write_reg(CFG_CRC_SEED, 16'hFFFF);
        send_char("a");
        send_char("b");
        write_reg(CFG_CRC_SEED, 16'h1234);
        send_char("c");
        send_char("d");
        send_char(CHAR_CR);
        send_char(CHAR_LF);

        // writes to the unused index are dropped
        write_reg(CFG_UNUSED, 16'hFFFF);
        write_reg(CFG_MAX_KEPT, 16'(MAX_KEPT_RST));
        write_reg(CFG_CRC_SKIP, 16'(CRC_SKIP_RST));

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    snd_idle_pct = 7;
                    rcv_idle_pct = 65;
                end
                1: begin
                    snd_idle_pct = 65;
                    rcv_idle_pct = 7;
                end
                default: begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                end
            endcase
            phase_start = chars_sent;
            while (chars_sent - phase_start < PHASE_CHARS) random_sentence();
        end

        wait_drained();
        $display("covered %0d characters, %0d sentences closed, %0d framed words checked",
                 chars_sent, sentences, words_checked);
        $display("%0d register writes under three pacing phases", reg_writes);
        if (fail_count == 0 && pending == 0) begin
            $display("telemetry_sentence_framer_crc16_tb passed");
        end else begin
            $display("telemetry_sentence_framer_crc16_tb failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/tsf_pkg.sv
design/tsf_stream_if.sv
design/tsf_filter.sv
design/tsf_tail.sv
design/telemetry_sentence_framer_crc16.sv
sim/tsf_framer_checker.sv
sim/telemetry_sentence_framer_crc16_tb.sv
